[sv/b2r_pkg.sv]
// Shared types, constants and digit pattern functions for the Roman numeral converter.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package b2r_pkg;

	// Accepted value range, inclusive.
	localparam logic [15:0] RANGE_LOW  = 16'd1000;
	localparam logic [15:0] RANGE_HIGH = 16'd3000;

	// Widths of the payload fields.
	localparam int VALUE_W  = 16;
	localparam int SYMBOL_W = 7;
	localparam int REM_W    = 12;
	localparam int DIGIT_W  = 4;
	localparam int NUM_DIGITS = 4;

	// ASCII codes of the Roman symbols.
	localparam logic [SYMBOL_W-1:0] SYM_I = 7'h49;
	localparam logic [SYMBOL_W-1:0] SYM_V = 7'h56;
	localparam logic [SYMBOL_W-1:0] SYM_X = 7'h58;
	localparam logic [SYMBOL_W-1:0] SYM_L = 7'h4C;
	localparam logic [SYMBOL_W-1:0] SYM_C = 7'h43;
	localparam logic [SYMBOL_W-1:0] SYM_D = 7'h44;
	localparam logic [SYMBOL_W-1:0] SYM_M = 7'h4D;
	localparam logic [SYMBOL_W-1:0] SYM_NONE = 7'h00;

	// Role of a symbol within one decimal digit's pattern.
	typedef enum logic [1:0] {
		KIND_ONE,
		KIND_FIVE,
		KIND_TEN
	} sym_kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic conv;
		logic emit;
	} b2r_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic oor;
		logic conv_done;
		logic out_free;
		logic sym_last;
	} b2r_stat_t;

	// Place weight for the digit extracted at each conversion step.
	function automatic logic [13:0] place_weight(input logic [1:0] step);
		logic [13:0] w;
		case (step)
			2'd0:    w = 14'd1000;
			2'd1:    w = 14'd100;
			default: w = 14'd10;
		endcase
		return w;
	endfunction

	// Number of symbols that one decimal digit produces.
	function automatic logic [2:0] digit_len(input logic [DIGIT_W-1:0] d);
		logic [2:0] n;
		case (d)
			4'd1:    n = 3'd1;
			4'd2:    n = 3'd2;
			4'd3:    n = 3'd3;
			4'd4:    n = 3'd2;
			4'd5:    n = 3'd1;
			4'd6:    n = 3'd2;
			4'd7:    n = 3'd3;
			4'd8:    n = 3'd4;
			4'd9:    n = 3'd2;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	// Which symbol of the digit's set stands at a position in its pattern.
	function automatic sym_kind_t digit_kind(input logic [DIGIT_W-1:0] d,
			input logic [1:0] pos);
		sym_kind_t k;
		if (d == 4'd9) begin
			k = (pos == 2'd0) ? KIND_ONE : KIND_TEN;
		end else if (d == 4'd4) begin
			k = (pos == 2'd0) ? KIND_ONE : KIND_FIVE;
		end else if (d >= 4'd5 && pos == 2'd0) begin
			k = KIND_FIVE;
		end else begin
			k = KIND_ONE;
		end
		return k;
	endfunction

	// Symbol set of each digit place, thousands first.
	function automatic logic [SYMBOL_W-1:0] place_symbol(input logic [1:0] place,
			input sym_kind_t kind);
		logic [SYMBOL_W-1:0] s;
		case (place)
			2'd0: s = SYM_M;
			2'd1: begin
				case (kind)
					KIND_ONE:  s = SYM_C;
					KIND_FIVE: s = SYM_D;
					default:   s = SYM_M;
				endcase
			end
			2'd2: begin
				case (kind)
					KIND_ONE:  s = SYM_X;
					KIND_FIVE: s = SYM_L;
					default:   s = SYM_C;
				endcase
			end
			default: begin
				case (kind)
					KIND_ONE:  s = SYM_I;
					KIND_FIVE: s = SYM_V;
					default:   s = SYM_X;
				endcase
			end
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

[sv/binary_to_roman_numeral.sv]
// Top level of the binary to Roman numeral converter.
// Depends on b2r_pkg, b2r_ctrl and b2r_datapath.
//
// Channel  Dir  Fields (tdata / tuser / tlast)
// s_*      in   tdata[15:0] value
// m_*      out  tdata[6:0] symbol, tdata[7] zero; tuser out_of_range; tlast last
//
// A request is captured, then its digits are extracted in the compare-subtract unit,
// one per place, then its symbols are emitted in order: up to 14 symbols in range,
// a single symbol out of range.
// Reset clears the controller state and the output valid flag.
// A stalled output holds the sequencer; a new request is taken once the
// previous request's final symbol sits in the output register.
`default_nettype none

module binary_to_roman_numeral (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // [15:0] value
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // [6:0] symbol, [7] zero
	output logic             m_tuser,  // [0] out_of_range
	output logic             m_tlast
);

	b2r_pkg::b2r_cmd_t               cmd;
	b2r_pkg::b2r_stat_t              stat;
	logic [b2r_pkg::SYMBOL_W-1:0]    symbol;

	// Sequencing of capture, conversion and emission.
	b2r_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	// Digit extraction and symbol output.
	b2r_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.value        (s_tdata),
		.stat         (stat),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.symbol       (symbol),
		.out_of_range (m_tuser),
		.last         (m_tlast)
	);

	assign m_tdata = {1'b0, symbol};

endmodule

`default_nettype wire

[sv/b2r_ctrl.sv]
// Controller state machine of the Roman numeral converter.
// Depends on b2r_pkg for the command and status structs.
`default_nettype none

module b2r_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	output b2r_pkg::b2r_cmd_t      cmd,
	input  wire b2r_pkg::b2r_stat_t stat
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	// Commands and next state.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				// An out-of-range request needs no digits.
				if (stat.oor) begin
					state_d = ST_EMIT;
				end else begin
					cmd.conv = 1'b1;
					if (stat.conv_done) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.sym_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[sv/b2r_datapath.sv]
// Datapath of the Roman numeral converter: range check, digit extraction,
// symbol sequencing and the output register. Depends on b2r_pkg.
`default_nettype none

module b2r_datapath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire b2r_pkg::b2r_cmd_t              cmd,
	input  wire logic [b2r_pkg::VALUE_W-1:0]    value,
	output b2r_pkg::b2r_stat_t                  stat,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [b2r_pkg::SYMBOL_W-1:0]        symbol,
	output logic                                out_of_range,
	output logic                                last
);

	logic                            oor_q;
	logic [b2r_pkg::REM_W-1:0]       rem_q;
	logic [1:0]                      conv_idx_q;
	logic [b2r_pkg::DIGIT_W-1:0]     dig_q [b2r_pkg::NUM_DIGITS];
	logic [1:0]                      place_q;
	logic [1:0]                      pos_q;
	logic                            m_valid_q;
	logic [b2r_pkg::SYMBOL_W-1:0]    sym_q;
	logic                            oor_out_q;
	logic                            last_q;

	logic [b2r_pkg::DIGIT_W-1:0]     conv_digit;
	logic [13:0]                     conv_sub;
	logic [13:0]                     rem_ext;
	logic [13:0]                     weight;
	logic [13:0]                     rem_next;

	logic [b2r_pkg::DIGIT_W-1:0]     cur_digit;
	logic [2:0]                      cur_len;
	logic                            pos_end;
	logic                            next_found;
	logic [1:0]                      next_place;
	logic [b2r_pkg::SYMBOL_W-1:0]    cur_sym;

	// One decimal digit per step: compare the remainder with all nine multiples.
	always_comb begin
		rem_ext    = {2'b00, rem_q};
		weight     = b2r_pkg::place_weight(conv_idx_q);
		conv_digit = '0;
		conv_sub   = '0;
		for (int j = 1; j <= 9; j++) begin
			if (rem_ext >= 14'(j) * weight) begin
				conv_digit = 4'(j);
				conv_sub   = 14'(j) * weight;
			end
		end
		rem_next = rem_ext - conv_sub;
	end

	// Current symbol and the position of the one after it.
	always_comb begin
		cur_digit  = dig_q[place_q];
		cur_len    = b2r_pkg::digit_len(cur_digit);
		pos_end    = ({1'b0, pos_q} + 3'd1) >= cur_len;
		next_found = 1'b0;
		next_place = place_q;
		for (int k = 1; k < b2r_pkg::NUM_DIGITS; k++) begin
			if (!next_found && 2'(k) > place_q && b2r_pkg::digit_len(dig_q[k]) != 3'd0) begin
				next_found = 1'b1;
				next_place = 2'(k);
			end
		end
		cur_sym = b2r_pkg::place_symbol(place_q, b2r_pkg::digit_kind(cur_digit, pos_q));
	end

	assign stat.oor       = oor_q;
	assign stat.conv_done = (conv_idx_q == 2'd2);
	assign stat.out_free  = !m_valid_q || m_tready;
	assign stat.sym_last  = oor_q || (pos_end && !next_found);

	// Request capture, digit extraction and symbol pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oor_q      <= 1'b0;
			rem_q      <= '0;
			conv_idx_q <= '0;
			place_q    <= '0;
			pos_q      <= '0;
			for (int i = 0; i < b2r_pkg::NUM_DIGITS; i++) begin
				dig_q[i] <= '0;
			end
		end else begin
			if (cmd.load) begin
				oor_q      <= (value < b2r_pkg::RANGE_LOW) || (value > b2r_pkg::RANGE_HIGH);
				rem_q      <= value[b2r_pkg::REM_W-1:0];
				conv_idx_q <= '0;
				place_q    <= '0;
				pos_q      <= '0;
			end
			if (cmd.conv) begin
				dig_q[conv_idx_q] <= conv_digit;
				rem_q             <= rem_next[b2r_pkg::REM_W-1:0];
				conv_idx_q        <= conv_idx_q + 2'd1;
				// The last step leaves the ones digit as the remainder.
				if (conv_idx_q == 2'd2) begin
					dig_q[3] <= rem_next[b2r_pkg::DIGIT_W-1:0];
				end
			end
			if (cmd.emit) begin
				if (pos_end) begin
					place_q <= next_place;
					pos_q   <= '0;
				end else begin
					pos_q <= pos_q + 2'd1;
				end
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			sym_q     <= oor_q ? b2r_pkg::SYM_NONE : cur_sym;
			oor_out_q <= oor_q;
			last_q    <= stat.sym_last;
		end
	end

	assign m_tvalid     = m_valid_q;
	assign symbol       = sym_q;
	assign out_of_range = oor_out_q;
	assign last         = last_q;

endmodule

`default_nettype wire

[tb/sv/binary_to_roman_numeral_test.sv]
// Self-checking testbench for binary_to_roman_numeral: drives values over the input stream
// and checks every Roman symbol against a predictor kept in a small scoreboard class.
// Depends on b2r_pkg and the binary_to_roman_numeral RTL.
`timescale 1ns / 100ps

module binary_to_roman_numeral_test;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 24;
	localparam int RANDOM_VALUES  = 285;

	// One symbol result as the block should emit it.
	typedef struct packed {
		logic [b2r_pkg::SYMBOL_W-1:0] symbol;
		logic                         out_of_range;
		logic                         last;
	} roman_symbol_t;

	// Predicts the symbol run of each request and checks results in order.
	class roman_scoreboard;
		roman_symbol_t pending_symbols[$];
		int            mismatches;

		function new();
			mismatches = 0;
		endfunction

		// Appends the pattern of one decimal digit below the thousands place.
		function void spell_digit(input int d, input logic [b2r_pkg::SYMBOL_W-1:0] one,
				input logic [b2r_pkg::SYMBOL_W-1:0] five,
				input logic [b2r_pkg::SYMBOL_W-1:0] ten,
				ref logic [b2r_pkg::SYMBOL_W-1:0] run[$]);
			int n;
			n = d;
			if (d == 9) begin
				run.push_back(one);
				run.push_back(ten);
			end else if (d == 4) begin
				run.push_back(one);
				run.push_back(five);
			end else begin
				if (n >= 5) begin
					run.push_back(five);
					n = n - 5;
				end
				repeat (n) run.push_back(one);
			end
		endfunction

		// Works out the expected results of one accepted request.
		function void note_request(input logic [b2r_pkg::VALUE_W-1:0] value);
			logic [b2r_pkg::SYMBOL_W-1:0] run[$];
			roman_symbol_t                r;
			int                           v;
			v = value;
			if (value < b2r_pkg::RANGE_LOW || value > b2r_pkg::RANGE_HIGH) begin
				r.symbol       = b2r_pkg::SYM_NONE;
				r.out_of_range = 1'b1;
				r.last         = 1'b1;
				pending_symbols.push_back(r);
			end else begin
				repeat (v / 1000) run.push_back(b2r_pkg::SYM_M);
				spell_digit((v / 100) % 10, b2r_pkg::SYM_C, b2r_pkg::SYM_D,
					b2r_pkg::SYM_M, run);
				spell_digit((v / 10) % 10, b2r_pkg::SYM_X, b2r_pkg::SYM_L,
					b2r_pkg::SYM_C, run);
				spell_digit(v % 10, b2r_pkg::SYM_I, b2r_pkg::SYM_V,
					b2r_pkg::SYM_X, run);
				foreach (run[k]) begin
					r.symbol       = run[k];
					r.out_of_range = 1'b0;
					r.last         = (k == run.size() - 1);
					pending_symbols.push_back(r);
				end
			end
		endfunction

		// Compares one accepted result with the oldest expectation.
		function void check_symbol(input logic [7:0] tdata, input logic tuser,
				input logic tlast);
			roman_symbol_t exp_sym;
			if (pending_symbols.size() == 0) begin
				mismatches++;
				$display("%0t: expected no result, got tdata=%h tuser=%b tlast=%b",
					$time, tdata, tuser, tlast);
				return;
			end
			exp_sym = pending_symbols.pop_front();
			if (tdata[6:0] !== exp_sym.symbol || tdata[7] !== 1'b0 ||
					tuser !== exp_sym.out_of_range || tlast !== exp_sym.last) begin
				mismatches++;
				$display("%0t: expected symbol=%h pad=0 oor=%b last=%b,",
					$time, exp_sym.symbol, exp_sym.out_of_range, exp_sym.last);
				$display("%0t:      got symbol=%h pad=%b oor=%b last=%b",
					$time, tdata[6:0], tdata[7], tuser, tlast);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	int send_idle_pct;
	int recv_idle_pct;

	roman_scoreboard board = new();

	binary_to_roman_numeral dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Free-running clock, 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Output backpressure, redrawn every cycle.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Every accepted result goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_symbol(m_tdata, m_tuser, m_tlast);
	end

	// Offers one request, with random idle cycles ahead of it, and waits for it to be taken.
	task automatic send_value(input logic [15:0] value);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 16'($urandom);
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		board.note_request(value);
	endtask

	// Mostly in-range values, some close to the bounds, the rest over the whole field.
	function automatic logic [15:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return 16'($urandom_range(3000, 1000));
		else if (r < 78)
			return 16'($urandom_range(1010, 990));
		else if (r < 86)
			return 16'($urandom_range(3010, 2990));
		else
			return 16'($urandom);
	endfunction

	// Ends the run if neither side moves a request for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Reset, directed values, three random phases with different idling, then drain.
	initial begin
		logic [15:0] directed_values[$];
		directed_values = {16'd0, 16'd999, 16'd1000, 16'd3000, 16'd3001, 16'd65535,
			16'd2888, 16'd1994, 16'd1444, 16'd1999, 16'd2000, 16'd1004, 16'd1009,
			16'd1040, 16'd1090, 16'd1400, 16'd1900, 16'd1555, 16'd2777, 16'd1666,
			16'd2349, 16'd32768, 16'd1023, 16'd2047, 16'd1001};
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		send_idle_pct = 7;
		recv_idle_pct = 50;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_values[i]) send_value(directed_values[i]);
		repeat (RANDOM_VALUES / 3) send_value(pick_value());

		send_idle_pct = 50;
		recv_idle_pct = 7;
		repeat (RANDOM_VALUES / 3) send_value(pick_value());

		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (RANDOM_VALUES - 2 * (RANDOM_VALUES / 3)) send_value(pick_value());

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (board.pending_symbols.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.mismatches == 0 && board.pending_symbols.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
